@@ design/pwrf_pkg.sv @@
package pwrf_pkg;

  // Low bits of the edge timestamp that take part in the width
  localparam int StampBits = 32;

  localparam int DistBits    = 32;
  localparam int VelBits     = 41;
  localparam int AccBits     = 50;
  localparam int RateBits    = 8;
  localparam int CfgIdxBits  = 2;
  localparam int CfgDataBits = 32;

  localparam logic [CfgIdxBits-1:0] REG_MAX_DISTANCE = 2'd0;
  localparam logic [CfgIdxBits-1:0] REG_MAX_JUMP     = 2'd1;
  localparam logic [CfgIdxBits-1:0] REG_HEALTH_LIMIT = 2'd2;
  localparam logic [CfgIdxBits-1:0] REG_RATE_FACTOR  = 2'd3;

  localparam logic [DistBits-1:0] MaxDistanceReset = 32'd18000;
  localparam logic [DistBits-1:0] MaxJumpReset     = 32'd3000;
  localparam logic [DistBits-1:0] HealthLimitReset = 32'd38000;
  localparam logic [RateBits-1:0] RateFactorReset  = 8'd20;

  typedef struct packed {
    logic [DistBits-1:0] max_distance;
    logic [DistBits-1:0] max_jump;
    logic [DistBits-1:0] health_limit;
    logic [RateBits-1:0] rate_factor;
  } cfg_t;

endpackage

@@ design/pwrf_edge_if.sv @@
interface pwrf_edge_if import pwrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [DistBits-1:0] edge_time_us;

  modport source (output valid, output edge_time_us, input ready);
  modport sink (input valid, input edge_time_us, output ready);
endinterface

@@ design/pwrf_result_if.sv @@
interface pwrf_result_if import pwrf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [DistBits-1:0]       raw_distance;
  logic [DistBits-1:0]       held_distance;
  logic signed [VelBits-1:0] velocity;
  logic signed [AccBits-1:0] acceleration;
  logic                      rejected;
  logic                      healthy;
  logic                      pair_tick;

  modport source (output valid, output raw_distance, output held_distance,
                  output velocity, output acceleration, output rejected,
                  output healthy, output pair_tick, input ready);
  modport sink (input valid, input raw_distance, input held_distance,
                input velocity, input acceleration, input rejected,
                input healthy, input pair_tick, output ready);
endinterface

@@ design/pwrf_cfg_if.sv @@
interface pwrf_cfg_if import pwrf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CfgIdxBits-1:0]  index;
  logic [CfgDataBits-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/pwrf_cfg_regs.sv @@
module pwrf_cfg_regs import pwrf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  pwrf_cfg_if.sink   cfg,
  output cfg_t       regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.max_distance <= MaxDistanceReset;
      regs.max_jump     <= MaxJumpReset;
      regs.health_limit <= HealthLimitReset;
      regs.rate_factor  <= RateFactorReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAX_DISTANCE: regs.max_distance <= cfg.data[DistBits-1:0];
        REG_MAX_JUMP:     regs.max_jump     <= cfg.data[DistBits-1:0];
        REG_HEALTH_LIMIT: regs.health_limit <= cfg.data[DistBits-1:0];
        REG_RATE_FACTOR:  regs.rate_factor  <= cfg.data[RateBits-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/pulse_width_range_filter.sv @@
// Pulse-width range filter.
// edges: one request per captured pin edge, carrying its microsecond stamp.
//   Requests alternate start edge / end edge, starting with a start edge
//   after reset. A start edge only stores its stamp; an end edge makes one
//   result request.
// results: raw width (microseconds), held distance, velocity, acceleration and the
//   rejected / healthy / pair_tick flags.
// cfg: register writes (index, data), always ready; write only while idle.
// Throughput: one edge per cycle unless a receiver stall has filled the stages.
//   An end edge's result passes the stage 1, 2 and 3 registers before results.valid rises.
// Three register stages: width subtract, filter and velocity multiply,
//   acceleration multiply and health compare.
// Each stage moves up whenever the stage after it is empty or moving, so
//   edges keep being taken while a result waits; when the receiver stalls,
//   the three stages fill and edges.ready drops.
// Reset (synchronous): registers return to their defaults, all history
//   (start stamp, previous sample, velocity, held distance, pair count) is
//   cleared and the pipeline is emptied.
module pulse_width_range_filter import pwrf_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  pwrf_edge_if.sink      edges,
  pwrf_result_if.source  results,
  pwrf_cfg_if.sink       cfg
);

  cfg_t regs;

  pwrf_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // edge tracking
  logic                 awaiting_end;
  logic [StampBits-1:0] start_stamp;
  logic [StampBits-1:0] stamp;
  logic [StampBits-1:0] width;

  // history
  logic [DistBits-1:0]       prev_raw;
  logic [DistBits-1:0]       last_accepted;
  logic signed [VelBits-1:0] prev_vel;
  logic                      pair_count;

  // stage registers
  logic                      v1, v2, v3;
  logic [DistBits-1:0]       raw1, raw2, raw3;
  logic [DistBits-1:0]       held2, held3;
  logic signed [VelBits-1:0] vel2, vel3;
  logic signed [AccBits-1:0] acc3;
  logic                      rej2, rej3, tick2, tick3, healthy3;

  logic rdy1, rdy2, rdy3;
  logic in_fire, fire2, fire3;

  logic signed [DistBits:0]            diff;
  logic signed [DistBits+RateBits+1:0] vel_prod;
  logic [DistBits:0]                   jump;
  logic                                rej_c;
  logic [DistBits-1:0]                 held_c;
  logic signed [VelBits:0]             vel_delta;
  logic signed [VelBits+RateBits+1:0]  acc_prod;

  assign rdy3 = !v3 || results.ready;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign edges.ready = rdy1;

  assign in_fire = edges.valid && rdy1;
  assign fire2   = v1 && rdy2;
  assign fire3   = v2 && rdy3;

  assign stamp = edges.edge_time_us[StampBits-1:0];
  assign width = stamp - start_stamp;

  // stage 2: difference, velocity, range and jump tests
  assign diff     = $signed({1'b0, raw1}) - $signed({1'b0, prev_raw});
  assign vel_prod = $signed({1'b0, regs.rate_factor}) * diff;
  assign jump     = diff[DistBits] ? (DistBits+1)'(-diff) : (DistBits+1)'(diff);
  assign rej_c    = (raw1 > regs.max_distance) || (jump > {1'b0, regs.max_jump});
  assign held_c   = rej_c ? last_accepted : raw1;

  // stage 3: acceleration
  assign vel_delta = $signed({vel2[VelBits-1], vel2}) - $signed({prev_vel[VelBits-1], prev_vel});
  assign acc_prod  = $signed({1'b0, regs.rate_factor}) * vel_delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting_end  <= 1'b0;
      start_stamp   <= '0;
      prev_raw      <= '0;
      last_accepted <= '0;
      prev_vel      <= '0;
      pair_count    <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!awaiting_end) begin
          start_stamp  <= stamp;
          awaiting_end <= 1'b1;
        end else begin
          awaiting_end <= 1'b0;
        end
      end
      if (rdy1) begin
        v1 <= in_fire && awaiting_end;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      // rejected samples still advance the difference history
      if (fire2) begin
        prev_raw      <= raw1;
        last_accepted <= held_c;
        pair_count    <= ~pair_count;
      end
      if (fire3) begin
        prev_vel <= vel2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && awaiting_end && rdy1) begin
      raw1 <= DistBits'(width);
    end
    if (fire2) begin
      raw2  <= raw1;
      held2 <= held_c;
      vel2  <= vel_prod[VelBits-1:0];
      rej2  <= rej_c;
      tick2 <= pair_count;
    end
    if (fire3) begin
      raw3     <= raw2;
      held3    <= held2;
      vel3     <= vel2;
      acc3     <= acc_prod[AccBits-1:0];
      rej3     <= rej2;
      tick3    <= tick2;
      healthy3 <= (held2 != '0) && (held2 <= regs.health_limit);
    end
  end

  assign results.valid         = v3;
  assign results.raw_distance  = raw3;
  assign results.held_distance = held3;
  assign results.velocity      = vel3;
  assign results.acceleration  = acc3;
  assign results.rejected      = rej3;
  assign results.healthy       = healthy3;
  assign results.pair_tick     = tick3;

`ifndef NO_ASSERTIONS
  a_end_enters_pipe: assert property (@(posedge clk) disable iff (rst)
    (in_fire && awaiting_end) |=> (v1 && !awaiting_end))
    else $error("end edge did not enter the pipeline");

  a_stage2_to_out: assert property (@(posedge clk) disable iff (rst)
    fire2 |=> v2)
    else $error("stage 2 lost a sample");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    fire3 |=> results.valid)
    else $error("result register not loaded");

  a_accept_holds_raw: assert property (@(posedge clk) disable iff (rst)
    (v3 && !rej3) |-> (held3 == raw3))
    else $error("accepted sample not held");

  a_pair_toggle: assert property (@(posedge clk) disable iff (rst)
    fire2 |=> (pair_count != $past(pair_count)))
    else $error("pair count did not advance");
`endif

endmodule

@@ verif/pulse_width_range_filter_tb.sv @@
`timescale 1ns / 100ps

module pulse_width_range_filter_tb import pwrf_pkg::*;;

  localparam int CycleLimit = 300000;

  typedef struct {
    logic [DistBits-1:0] raw_distance;
    logic [DistBits-1:0] held_distance;
    logic [VelBits-1:0]  velocity;
    logic [AccBits-1:0]  acceleration;
    logic                rejected;
    logic                healthy;
    logic                pair_tick;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pwrf_edge_if   edges_if ();
  pwrf_result_if results_if ();
  pwrf_cfg_if    cfg_if ();

  pulse_width_range_filter u_dut (
    .clk     (clk),
    .rst     (rst),
    .edges   (edges_if),
    .results (results_if),
    .cfg     (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register shadow
  logic [DistBits-1:0] cfg_max_distance = MaxDistanceReset;
  logic [DistBits-1:0] cfg_max_jump     = MaxJumpReset;
  logic [DistBits-1:0] cfg_health_limit = HealthLimitReset;
  logic [RateBits-1:0] cfg_rate         = RateFactorReset;

  // Filter history shadow
  logic                st_awaiting_end  = 1'b0;
  logic [DistBits-1:0] st_start_stamp   = '0;
  logic [DistBits-1:0] st_prev_raw      = '0;
  longint              st_prev_vel      = 0;
  logic [DistBits-1:0] st_last_accepted = '0;
  logic                st_pair_odd      = 1'b0;

  reading_t    pending_readings[$];
  reading_t    want;
  int unsigned error_count = 0;
  int unsigned result_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_len = 0;
  bit          src_gaps = 1'b1;
  bit          sink_gaps = 1'b1;
  logic [31:0] now_us = 32'h0000_1000;

  task automatic report(input string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  task automatic track_edge(input logic [DistBits-1:0] stamp);
    reading_t            r;
    logic [DistBits-1:0] raw;
    logic [DistBits-1:0] jump;
    longint              raw_l;
    longint              prev_l;
    longint              rate_l;
    longint              vel_l;
    longint              acc_l;
    if (!st_awaiting_end) begin
      st_start_stamp  = '0;
      st_start_stamp[StampBits-1:0] = stamp[StampBits-1:0];
      st_awaiting_end = 1'b1;
    end else begin
      st_awaiting_end = 1'b0;
      raw = '0;
      raw[StampBits-1:0] = stamp[StampBits-1:0] - st_start_stamp[StampBits-1:0];
      raw_l  = {32'd0, raw};
      prev_l = {32'd0, st_prev_raw};
      rate_l = {56'd0, cfg_rate};
      vel_l  = rate_l * (raw_l - prev_l);
      acc_l  = rate_l * (vel_l - st_prev_vel);
      jump = (raw >= st_prev_raw) ? raw - st_prev_raw : st_prev_raw - raw;
      r.rejected = (raw > cfg_max_distance) || (jump > cfg_max_jump);
      if (!r.rejected) st_last_accepted = raw;
      r.raw_distance  = raw;
      r.held_distance = st_last_accepted;
      r.healthy = (st_last_accepted > 0) && (st_last_accepted <= cfg_health_limit);
      r.pair_tick = st_pair_odd;
      r.velocity     = vel_l[VelBits-1:0];
      r.acceleration = acc_l[AccBits-1:0];
      st_pair_odd = ~st_pair_odd;
      st_prev_raw = raw;
      st_prev_vel = vel_l;
      pending_readings.push_back(r);
    end
  endtask

  task automatic send_edge(input logic [DistBits-1:0] stamp);
    int gap;
    gap = src_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      edges_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edges_if.valid        <= 1'b1;
    edges_if.edge_time_us <= stamp;
    @(posedge clk);
    while (!edges_if.ready) @(posedge clk);
    track_edge(stamp);
  endtask

  task automatic send_pulse(input logic [DistBits-1:0] start, input logic [DistBits-1:0] width);
    send_edge(start);
    send_edge(start + width);
  endtask

  // Stop offering, let every outstanding result land, then cover the
  // pipeline depth so a trailing start edge is through too.
  task automatic wait_drained();
    edges_if.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx,
                           input logic [CfgDataBits-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_MAX_DISTANCE: cfg_max_distance = value;
      REG_MAX_JUMP:     cfg_max_jump = value;
      REG_HEALTH_LIMIT: cfg_health_limit = value;
      REG_RATE_FACTOR:  cfg_rate = value[RateBits-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] max_dist, input logic [31:0] max_jump,
                             input logic [31:0] health, input logic [31:0] rate_word);
    wait_drained();
    write_reg(REG_MAX_DISTANCE, max_dist);
    write_reg(REG_MAX_JUMP, max_jump);
    write_reg(REG_HEALTH_LIMIT, health);
    write_reg(REG_RATE_FACTOR, rate_word);
    cfg_if.valid <= 1'b0;
  endtask

  // Mostly widths near the previous sample and near the jump / limit edges
  function automatic logic [31:0] pick_width();
    logic [31:0] lim;
    lim = (cfg_max_jump > 4000) ? 32'd4000 : cfg_max_jump;
    case ($urandom_range(0, 9))
      0: pick_width = $urandom();
      1: pick_width = $urandom_range(0, 3);
      2: pick_width = st_prev_raw + cfg_max_jump;
      3: pick_width = st_prev_raw + cfg_max_jump + 1;
      4: pick_width = st_prev_raw - cfg_max_jump;
      5: pick_width = cfg_max_distance + $urandom_range(0, 2) - 1;
      default: pick_width = st_prev_raw + $urandom_range(0, 2 * lim) - lim;
    endcase
  endfunction

  // Receiver: random stalls per result, plus a long hold-off on request
  initial begin
    int stall;
    results_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        results_if.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      stall = sink_gaps ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        results_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (!results_if.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      result_count++;
      if (pending_readings.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", result_count));
      end else begin
        want = pending_readings.pop_front();
        if (results_if.raw_distance !== want.raw_distance)
          report($sformatf("result %0d raw_distance %h, want %h", result_count,
                           results_if.raw_distance, want.raw_distance));
        if (results_if.held_distance !== want.held_distance)
          report($sformatf("result %0d held_distance %h, want %h", result_count,
                           results_if.held_distance, want.held_distance));
        if (results_if.velocity !== want.velocity)
          report($sformatf("result %0d velocity %h, want %h", result_count,
                           results_if.velocity, want.velocity));
        if (results_if.acceleration !== want.acceleration)
          report($sformatf("result %0d acceleration %h, want %h", result_count,
                           results_if.acceleration, want.acceleration));
        if (results_if.rejected !== want.rejected)
          report($sformatf("result %0d rejected %b, want %b", result_count,
                           results_if.rejected, want.rejected));
        if (results_if.healthy !== want.healthy)
          report($sformatf("result %0d healthy %b, want %b", result_count,
                           results_if.healthy, want.healthy));
        if (results_if.pair_tick !== want.pair_tick)
          report($sformatf("result %0d pair_tick %b, want %b", result_count,
                           results_if.pair_tick, want.pair_tick));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_readings.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Reset register values; first sample is judged against a zero history,
  // then jump exactly at and just over the limit, over max distance, zero width.
  task automatic test_reset_defaults();
    send_pulse(32'h0000_0100, 32'd1000);
    send_pulse(32'h0001_0000, 32'd4000);
    send_pulse(32'h0002_0000, 32'd7001);
    send_pulse(32'h0003_0000, 32'd18001);
    send_pulse(32'h0004_0000, 32'd18000);
    send_pulse(32'h0005_0000, 32'd0);
  endtask

  // Counter wrap between the edges, and the widest possible pulse
  task automatic test_stamp_wrap();
    send_pulse(32'hFFFF_FF00, 32'h0000_0200);
    send_pulse(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_register_extremes();
    load_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_00FF);
    send_pulse(32'h0000_0000, 32'hFFFF_FFFF);
    send_pulse(32'h1000_0000, 32'h0000_0000);
    send_pulse(32'h2000_0000, 32'hFFFF_FFFF);
    load_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FF01);
    send_pulse(32'h3000_0000, 32'd0);
    send_pulse(32'h3000_1000, 32'd5);
    // rate factor zero: differences vanish
    load_config(32'd18000, 32'd3000, 32'd38000, 32'hFFFF_FF00);
    send_pulse(32'h4000_0000, 32'd1200);
  endtask

  // Receiver holds off while the sender keeps going: pipeline must fill
  // and throttle edge requests without losing anything.
  task automatic test_result_backpressure();
    load_config(32'd40000, 32'd5000, 32'd38000, 32'd37);
    src_gaps = 1'b0;
    hold_len = 80;
    repeat (20) begin
      send_pulse(now_us, $urandom_range(0, 40000));
      now_us += $urandom_range(50000, 60000);
    end
    wait_drained();
    src_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [31:0] max_dist;
    logic [31:0] max_jump;
    logic [31:0] health;
    logic [7:0]  rate;
    repeat (10) begin
      case ($urandom_range(0, 3))
        0: max_dist = $urandom();
        1: max_dist = 32'hFFFF_FFFF;
        default: max_dist = $urandom_range(5000, 40000);
      endcase
      case ($urandom_range(0, 3))
        0: max_jump = $urandom();
        1: max_jump = $urandom_range(0, 50);
        default: max_jump = $urandom_range(500, 6000);
      endcase
      case ($urandom_range(0, 3))
        0: health = $urandom();
        1: health = st_last_accepted;
        default: health = $urandom_range(0, 40000);
      endcase
      case ($urandom_range(0, 3))
        0: rate = 8'd255;
        1: rate = 8'd1;
        default: rate = $urandom_range(2, 254);
      endcase
      load_config(max_dist, max_jump, health, ($urandom() & 32'hFFFF_FF00) | rate);
      src_gaps  = ($urandom_range(0, 3) != 0);
      sink_gaps = ($urandom_range(0, 3) != 0);
      repeat (60) begin
        if ($urandom_range(0, 19) == 0) begin
          // stray edge: knocks start/end pairing out of step
          send_edge($urandom());
        end else begin
          if (st_awaiting_end && $urandom_range(0, 3) != 0) send_edge(now_us);
          send_pulse(now_us, pick_width());
          now_us = ($urandom_range(0, 15) == 0) ? $urandom()
                                               : now_us + $urandom_range(0, 100000);
        end
      end
    end
  endtask

  initial begin
    edges_if.valid        = 1'b0;
    edges_if.edge_time_us = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.index          = REG_MAX_DISTANCE;
    cfg_if.data           = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_stamp_wrap();
    test_register_extremes();
    test_result_backpressure();
    test_random_traffic();
    wait_drained();
    repeat (6) @(posedge clk);
    if (pending_readings.size() != 0)
      report($sformatf("%0d results never arrived", pending_readings.size()));
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/pwrf_pkg.sv
design/pwrf_edge_if.sv
design/pwrf_result_if.sv
design/pwrf_cfg_if.sv
design/pwrf_cfg_regs.sv
design/pulse_width_range_filter.sv
verif/pulse_width_range_filter_tb.sv
